// ===== sv/rlkd_pkg.sv =====
// ----------------------------------------------------------------------------
// rlkd_pkg
// Shared types, widths and the key threshold table for the ladder keypad
// debouncer.
// ----------------------------------------------------------------------------
package rlkd_pkg;

   localparam int RAW_WIDTH    = 16;
   localparam int COARSE_SHIFT = 4;
   localparam int COARSE_WIDTH = RAW_WIDTH - COARSE_SHIFT;
   localparam int KEY_WIDTH    = 4;
   localparam int NUM_BOUNDS   = 11;

   localparam logic [RAW_WIDTH-1:0] MIN_LEVEL_RESET = 16'd16;
   localparam logic [KEY_WIDTH-1:0] KEY_LAST        = 4'd11;

   localparam logic [COARSE_WIDTH-1:0] KEY_BOUNDS [0:NUM_BOUNDS-1] = '{
      12'd4, 12'd8, 12'd12, 12'd14, 12'd18, 12'd21,
      12'd23, 12'd27, 12'd31, 12'd35, 12'd38
   };

   typedef struct packed {
      logic                 valid;
      logic [RAW_WIDTH-1:0] raw_sample;
   } stage_type;

   function automatic logic [KEY_WIDTH-1:0] quantize_key(input logic [COARSE_WIDTH-1:0] coarse);
      logic [KEY_WIDTH-1:0] key;
      key = KEY_LAST;
      for (int k = NUM_BOUNDS - 1; k >= 0; k--) begin
         if (coarse < KEY_BOUNDS[k]) begin
            key = KEY_WIDTH'(k);
         end
      end
      return key;
   endfunction

endpackage

// ===== sv/rlkd_req_if.sv =====
// ----------------------------------------------------------------------------
// rlkd_req_if
// Request channel: one raw converter reading per word.
// ----------------------------------------------------------------------------
interface rlkd_req_if import rlkd_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [RAW_WIDTH-1:0] raw_sample;

   modport source (output valid, output raw_sample, input ready);
   modport sink   (input valid, input raw_sample, output ready);

endinterface

// ===== sv/rlkd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rlkd_rsp_if
// Response channel: stable flag, previous flag and key number per word.
// ----------------------------------------------------------------------------
interface rlkd_rsp_if import rlkd_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic                 stable;
   logic                 was_stable;
   logic [KEY_WIDTH-1:0] key_number;

   modport source (output valid, output stable, output was_stable, output key_number,
                   input ready);
   modport sink   (input valid, input stable, input was_stable, input key_number,
                   output ready);

endinterface

// ===== sv/resistor_ladder_key_debouncer_top.sv =====
// ----------------------------------------------------------------------------
// resistor_ladder_key_debouncer_top
// Debounces and quantises resistor ladder keypad readings.
//
// Each request word carries one raw converter reading. A reading below the
// min level register drops the block to unstable and is not stored; any
// other reading is cut to its upper 12 bits and pushed into a line of the
// last HISTORY_DEPTH coarse samples. When the whole line agrees the block is
// stable and the key number (0 to 11) is taken from a fixed threshold table;
// otherwise the last key is held. Every request word gives one response
// word: stable, was_stable and key_number.
// A request word passes through the input register and then the response
// register; one word is taken every cycle while the receiver does not stall.
// When the receiver stalls, the response register and then the input register
// hold; the request side stalls once both are full. Reset clears the sample
// line to zeros, the flag and key to zero and sets min level to 16. Write min
// level only while the block is idle.
// ----------------------------------------------------------------------------
module resistor_ladder_key_debouncer_top import rlkd_pkg::*; #(
   parameter int HISTORY_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   rlkd_req_if.sink             req_if,
   rlkd_rsp_if.source           rsp_if,
   input  logic                 csr_wr_en,
   input  logic [RAW_WIDTH-1:0] csr_wr_data
);

   logic [RAW_WIDTH-1:0]    min_level_ff;
   stage_type               stage;
   logic                    advance;
   logic                    shift_en;
   logic [COARSE_WIDTH-1:0] coarse;
   logic                    all_equal;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_level_ff <= MIN_LEVEL_RESET;
      end else if (csr_wr_en) begin
         min_level_ff <= csr_wr_data;
      end
   end

   rlkd_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .advance (advance),
      .stage   (stage)
   );

   rlkd_history #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (shift_en),
      .coarse    (coarse),
      .all_equal (all_equal)
   );

   rlkd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .min_level (min_level_ff),
      .all_equal (all_equal),
      .advance   (advance),
      .shift_en  (shift_en),
      .coarse    (coarse),
      .rsp_if    (rsp_if)
   );

endmodule

// ===== sv/rlkd_in_stage.sv =====
// ----------------------------------------------------------------------------
// rlkd_in_stage
// Input register: captures one request word and holds it until the
// response stage takes it.
// ----------------------------------------------------------------------------
module rlkd_in_stage import rlkd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rlkd_req_if.sink  req_if,
   input  logic      advance,
   output stage_type stage
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [RAW_WIDTH-1:0] raw_ff;

   assign req_if.ready = !valid_ff || advance;
   assign valid_in     = req_if.ready ? req_if.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the word until it moves on
   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         raw_ff <= req_if.raw_sample;
      end
   end

   assign stage.valid      = valid_ff;
   assign stage.raw_sample = raw_ff;

endmodule

// ===== sv/rlkd_history.sv =====
// ----------------------------------------------------------------------------
// rlkd_history
// Line of the last coarse samples and the all-equal compare against the
// incoming sample.
// ----------------------------------------------------------------------------
module rlkd_history import rlkd_pkg::*; #(
   parameter int HISTORY_DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift_en,
   input  logic [COARSE_WIDTH-1:0] coarse,
   output logic                    all_equal
);

   logic [COARSE_WIDTH-1:0] hist_ff [HISTORY_DEPTH];

   // the oldest entry drops out, so only the newer ones need to match
   always_comb begin
      all_equal = 1'b1;
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
         if (hist_ff[i] != coarse) begin
            all_equal = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (shift_en) begin
         hist_ff[0] <= coarse;
         for (int i = 1; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

endmodule

// ===== sv/rlkd_out_stage.sv =====
// ----------------------------------------------------------------------------
// rlkd_out_stage
// Level check, key quantiser, stable and key state, and the response
// register.
// ----------------------------------------------------------------------------
module rlkd_out_stage import rlkd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  stage_type               stage,
   input  logic [RAW_WIDTH-1:0]    min_level,
   input  logic                    all_equal,
   output logic                    advance,
   output logic                    shift_en,
   output logic [COARSE_WIDTH-1:0] coarse,
   rlkd_rsp_if.source              rsp_if
);

   logic                 fire;
   logic                 level_ok;
   logic                 stable_in;
   logic [KEY_WIDTH-1:0] held_key_in;
   logic                 stable_ff;
   logic [KEY_WIDTH-1:0] held_key_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_stable_ff;
   logic                 rsp_was_stable_ff;
   logic [KEY_WIDTH-1:0] rsp_key_ff;

   assign advance   = !rsp_valid_ff || rsp_if.ready;
   assign fire      = stage.valid && advance;
   assign level_ok  = stage.raw_sample >= min_level;
   assign coarse    = stage.raw_sample[RAW_WIDTH-1:COARSE_SHIFT];
   assign shift_en  = fire && level_ok;
   assign stable_in = level_ok && all_equal;
   assign held_key_in = stable_in ? quantize_key(coarse) : held_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff    <= 1'b0;
         held_key_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            stable_ff   <= stable_in;
            held_key_ff <= held_key_in;
         end
         if (advance) begin
            rsp_valid_ff <= stage.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_stable_ff     <= stable_in;
         rsp_was_stable_ff <= stable_ff;
         rsp_key_ff        <= held_key_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.stable     = rsp_stable_ff;
   assign rsp_if.was_stable = rsp_was_stable_ff;
   assign rsp_if.key_number = rsp_key_ff;

   a_low_level_unstable: assert property (@(posedge clock) disable iff (reset)
      fire && !level_ok |=> !stable_ff)
      else $error("sample below min level left the state stable");

   a_was_stable_tracks: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_was_stable_ff == $past(stable_ff))
      else $error("was_stable does not match the previous flag");

   a_key_held: assert property (@(posedge clock) disable iff (reset)
      fire && !stable_in |=> held_key_ff == $past(held_key_ff))
      else $error("key changed while unstable");

   a_key_range: assert property (@(posedge clock) disable iff (reset)
      held_key_ff <= KEY_LAST)
      else $error("key number out of range");

endmodule
